@@ hw/rtl/page_framebuffer_rect_fill_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the page framebuffer fill engine
// Shorthand for clocked assertions on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_RECT_FILL_TOP_MACROS_SVH
`define PAGE_FRAMEBUFFER_RECT_FILL_TOP_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define PFRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be seen outside reset.
`define PFRF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hw/rtl/pfrf_pkg.sv @@
// ----------------------------------------------------------------------------
// Page framebuffer fill engine package
// Operation codes and fixed constants used by the engine's top level.
// ----------------------------------------------------------------------------
package pfrf_pkg;

  // Operation requested by one input transaction.
  typedef enum logic [2:0] {
    MODE_FILL    = 3'd0,
    MODE_HLINE   = 3'd1,
    MODE_VLINE   = 3'd2,
    MODE_OUTLINE = 3'd3,
    MODE_READ    = 3'd4
  } mode_e;

  localparam int unsigned PIXEL_BITS = 8;          // vertical pixels per byte
  localparam logic [7:0]  FULL_MASK  = 8'hFF;
  localparam int unsigned COORD_W    = 19;         // wide enough for any coordinate sum

  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

@@ hw/rtl/pfrf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pfrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/page_framebuffer_rect_fill_top.sv @@
// ----------------------------------------------------------------------------
// Page framebuffer rectangle fill engine
// Monochrome framebuffer in page layout with a clipped rectangle, line and
// outline painter and a byte read-back port.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Signals                 Contents
//  s_axis    in   tvalid/tready/tdata/    one drawing or read command
//                 tuser
//  m_axis    out  tvalid/tready/tdata     one result byte per command
//
// After reset the engine sweeps the whole store to zero, one byte a cycle, so
// it accepts no command until all PAGE_COUNT * SCREEN_W bytes are cleared. A
// drawing command is split into up to four rectangles; each passes set-up and
// clipping and then one fill step per covered byte, and the command ends in
// the next and done states. A read passes the read, read-wait and done states.
// The rate is set by the single read-modify-write path into the store RAM. The
// result waits in an output register, so the next command is taken while the
// previous result is still unclaimed; a command that finishes before the
// output is free holds there until the sink takes the waiting result.
// ----------------------------------------------------------------------------
`include "page_framebuffer_rect_fill_top_macros.svh"

module page_framebuffer_rect_fill_top #(
  parameter int unsigned SCREEN_W = 128,
  parameter int unsigned SCREEN_H = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] pos_x, [31:16] pos_y, [39:32] span_w, [47:40] span_h, [48] ink,
  // [58:49] read_addr, [63:59] zero
  input  logic [63:0] s_axis_tdata_i,
  // [2:0] mode
  input  logic [2:0]  s_axis_tuser_i,
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] read_data
  output logic [7:0]  m_axis_tdata_o
);

  import pfrf_pkg::*;

  // Store geometry. All widths follow from the screen size.
  localparam int unsigned PAGE_COUNT = (SCREEN_H + 7) / 8;
  localparam int unsigned STORE_SIZE = PAGE_COUNT * SCREEN_W;
  localparam int unsigned AW         = $clog2(STORE_SIZE);
  localparam int unsigned XW         = $clog2(SCREEN_W + 1);
  localparam int unsigned YW         = $clog2(SCREEN_H + 1);
  localparam int unsigned PGW        = YW - 3;

  localparam coord_t         SW_C     = COORD_W'(SCREEN_W);
  localparam coord_t         SH_C     = COORD_W'(SCREEN_H);
  localparam logic [AW:0]    SW_A     = (AW + 1)'(SCREEN_W);
  localparam logic [AW-1:0]  LAST_A   = AW'(STORE_SIZE - 1);
  localparam logic [31:0]    STORE_32 = 32'(STORE_SIZE);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_SETUP, ST_CLIP, ST_FILL, ST_NEXT, ST_RD, ST_RDW, ST_DONE
  } state_e;

  state_e state_q;

  // Command registers.
  logic [2:0]        mode_q;
  logic signed [15:0] px_q, py_q;
  logic [7:0]        w_q;
  logic signed [7:0] h_q;
  logic              ink_q;
  logic [9:0]        raddr_q;
  logic [1:0]        k_q;          // rectangle index within an outline

  // Current rectangle, unclipped then clipped.
  coord_t            rx0_q, rx1_q, ry0_q, ry1_q;
  logic              rvalid_q;
  logic [XW-1:0]     cx0_q, cx1_q, x_q;
  logic [YW-1:0]     cy0_q, cy1_q;
  logic [PGW-1:0]    pg_q, pglast_q;

  // Write-back stage of the read-modify-write pipeline.
  logic              wr_pend_q;
  logic [AW-1:0]     wr_addr_q;
  logic [7:0]        wr_mask_q;

  logic [AW-1:0]     clr_q;
  logic [7:0]        res_q;
  logic              m_tvalid_q;
  logic [7:0]        m_tdata_q;

  // RAM ports.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  pfrf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Rectangle selection: the outline is top row, bottom row, left and right
  // columns; the other drawing modes are a single rectangle.
  // --------------------------------------------------------------------------
  coord_t px_c, py_c, w_c, h_c;
  coord_t sx0, sy0, sw, sh;
  logic   s_valid;
  logic   last_k;

  assign px_c = COORD_W'(px_q);
  assign py_c = COORD_W'(py_q);
  assign w_c  = coord_t'({{(COORD_W-8){1'b0}}, w_q});
  assign h_c  = COORD_W'(h_q);

  always_comb begin
    sx0    = px_c;
    sy0    = py_c;
    sw     = w_c;
    sh     = h_c;
    last_k = 1'b1;
    case (mode_q)
      MODE_FILL: begin
      end
      MODE_HLINE: begin
        sh = coord_t'(1);
      end
      MODE_VLINE: begin
        sw = coord_t'(1);
      end
      MODE_OUTLINE: begin
        last_k = (k_q == 2'd3);
        case (k_q)
          2'd0: begin
            sh = coord_t'(1);
          end
          2'd1: begin
            sy0 = py_c + h_c - coord_t'(1);
            sh  = coord_t'(1);
          end
          2'd2: begin
            sy0 = py_c + coord_t'(1);
            sw  = coord_t'(1);
            sh  = h_c - coord_t'(2);
          end
          default: begin
            sx0 = px_c + w_c - coord_t'(1);
            sy0 = py_c + coord_t'(1);
            sw  = coord_t'(1);
            sh  = h_c - coord_t'(2);
          end
        endcase
      end
      default: begin
        sw = '0;
      end
    endcase
    // A degenerate outline draws none of its four parts.
    s_valid = (sw > 0) && (sh > 0) &&
              !((mode_q == MODE_OUTLINE) && ((w_q == 8'd0) || (h_q <= 0)));
  end

  // Clipping against the screen.
  coord_t kx0, kx1, ky0, ky1;
  logic   k_empty;

  always_comb begin
    kx0     = (rx0_q < 0) ? '0 : rx0_q;
    ky0     = (ry0_q < 0) ? '0 : ry0_q;
    kx1     = (rx1_q > SW_C) ? SW_C : rx1_q;
    ky1     = (ry1_q > SH_C) ? SH_C : ry1_q;
    k_empty = !rvalid_q || (kx0 >= kx1) || (ky0 >= ky1);
  end

  // Byte address and page mask of the current fill position.
  logic [AW:0]    fill_sum;
  logic [AW-1:0]  fill_addr;
  logic [YW:0]    pg_base;
  logic [2:0]     mask_lo;
  logic [3:0]     mask_hi;
  logic [7:0]     fill_mask;
  logic [YW-1:0]  cy1_m1;

  always_comb begin
    fill_sum  = (AW + 1)'(pg_q) * SW_A + (AW + 1)'(x_q);
    fill_addr = fill_sum[AW-1:0];
    pg_base   = {1'b0, pg_q, 3'b000};
    mask_lo   = ({1'b0, cy0_q} > pg_base) ? 3'(({1'b0, cy0_q} - pg_base)) : 3'd0;
    mask_hi   = ({1'b0, cy1_q} < (pg_base + (YW + 1)'(PIXEL_BITS))) ?
                4'(({1'b0, cy1_q} - pg_base)) : 4'd8;
    fill_mask = (FULL_MASK << mask_lo) & (FULL_MASK >> (4'd8 - mask_hi));
    cy1_m1    = ky1[YW-1:0] - YW'(1);
  end

  // RAM port steering: clearing sweep, write-back stage, or read-back.
  always_comb begin
    ram_we    = wr_pend_q;
    ram_waddr = wr_addr_q;
    ram_wdata = ink_q ? (ram_rdata | wr_mask_q) : (ram_rdata & ~wr_mask_q);
    ram_raddr = fill_addr;
    if (state_q == ST_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end
    if (state_q == ST_RD) begin
      ram_raddr = AW'(raddr_q);
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      clr_q      <= '0;
      wr_pend_q  <= 1'b0;
      m_tvalid_q <= 1'b0;
      k_q        <= '0;
    end else begin
      // A byte read during a fill cycle is written back in the next cycle.
      wr_pend_q <= (state_q == ST_FILL);
      // The done state hands over its own result, so it owns tvalid then.
      if (m_tvalid_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ST_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == LAST_A) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            mode_q  <= s_axis_tuser_i;
            px_q    <= s_axis_tdata_i[15:0];
            py_q    <= s_axis_tdata_i[31:16];
            w_q     <= s_axis_tdata_i[39:32];
            h_q     <= s_axis_tdata_i[47:40];
            ink_q   <= s_axis_tdata_i[48];
            raddr_q <= s_axis_tdata_i[58:49];
            k_q     <= '0;
            res_q   <= '0;
            state_q <= (s_axis_tuser_i == MODE_READ) ? ST_RD : ST_SETUP;
          end
        end
        ST_SETUP: begin
          rx0_q    <= sx0;
          ry0_q    <= sy0;
          rx1_q    <= sx0 + sw;
          ry1_q    <= sy0 + sh;
          rvalid_q <= s_valid;
          state_q  <= ST_CLIP;
        end
        ST_CLIP: begin
          cx0_q    <= kx0[XW-1:0];
          cx1_q    <= kx1[XW-1:0];
          cy0_q    <= ky0[YW-1:0];
          cy1_q    <= ky1[YW-1:0];
          x_q      <= kx0[XW-1:0];
          pg_q     <= ky0[YW-1:3];
          pglast_q <= cy1_m1[YW-1:3];
          state_q  <= k_empty ? ST_NEXT : ST_FILL;
        end
        ST_FILL: begin
          // Read this byte now; its modified value is written next cycle.
          wr_addr_q <= fill_addr;
          wr_mask_q <= fill_mask;
          if (x_q == cx1_q - XW'(1)) begin
            x_q <= cx0_q;
            if (pg_q == pglast_q) begin
              state_q <= ST_NEXT;
            end else begin
              pg_q <= pg_q + PGW'(1);
            end
          end else begin
            x_q <= x_q + XW'(1);
          end
        end
        ST_NEXT: begin
          if (last_k) begin
            state_q <= ST_DONE;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= ST_SETUP;
          end
        end
        ST_RD: begin
          state_q <= ST_RDW;
        end
        ST_RDW: begin
          res_q   <= ({22'b0, raddr_q} < STORE_32) ? ram_rdata : 8'h00;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid_q || m_axis_tready_i) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= res_q;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `PFRF_ASSERT(a_fill_in_bounds, (state_q == ST_FILL) |-> ((x_q >= cx0_q) && (x_q < cx1_q) && (pg_q <= pglast_q)), "fill position outside clipped rectangle")
  `PFRF_ASSERT(a_wb_in_store, wr_pend_q |-> ({{(32-AW){1'b0}}, wr_addr_q} < STORE_32), "write-back address beyond store")
  `PFRF_NEVER(a_no_write_on_read, wr_pend_q && ((state_q == ST_RD) || (state_q == ST_RDW)), "store written during a read-back")
  `PFRF_ASSERT(a_done_waits, ((state_q == ST_DONE) && m_tvalid_q && !m_axis_tready_i) |=> (state_q == ST_DONE), "result overwrote a waiting result")

endmodule
